### hw/rtl/sha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, round constants and round functions for the SHA-256 stream
// hasher: transaction structs, controller states, command and status groups.
// ----------------------------------------------------------------------------
package sha_pkg;

  // input item operation codes
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // padding marker byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // input and result transactions
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
  } out_item_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD2
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       absorb;
    logic       pad_first;
    logic       pad_second;
    logic       load_work;
    logic       round;
    logic       update;
    logic       emit;
    logic [5:0] round_idx;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fill_last;
    logic pad_two;
  } status_t;

  // initial hash values
  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round constants
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // round functions
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sha_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_ctrl
// Controller state machine: accepts transactions, sequences the 64 rounds,
// the chaining update and the second padding block, and owns result valid.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_op,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire sha_pkg::status_t status,
  output sha_pkg::cmd_t         cmd
);

  sha_pkg::state_t state_r, state_nxt;
  logic [5:0]      rnd_r, rnd_nxt;
  logic            final_r, final_nxt;
  logic            second_r, second_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            in_accept;

  // accept only when idle; a finish waits for the result register to drain
  assign in_stall  = (state_r != sha_pkg::ST_IDLE) ||
                     (out_valid_r && (in_op == sha_pkg::OP_FINISH));
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    final_nxt  = final_r;
    second_nxt = second_r;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_op == sha_pkg::OP_FINISH) begin
            state_nxt  = sha_pkg::ST_ROUND;
            final_nxt  = !status.pad_two;
            second_nxt = status.pad_two;
          end else if (status.fill_last) begin
            state_nxt  = sha_pkg::ST_ROUND;
            final_nxt  = 1'b0;
            second_nxt = 1'b0;
          end
        end
      end
      sha_pkg::ST_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = sha_pkg::ST_UPDATE;
        end
      end
      sha_pkg::ST_UPDATE: begin
        state_nxt = second_r ? sha_pkg::ST_PAD2 : sha_pkg::ST_IDLE;
      end
      sha_pkg::ST_PAD2: begin
        state_nxt  = sha_pkg::ST_ROUND;
        final_nxt  = 1'b1;
        second_nxt = 1'b0;
      end
      default: begin
        state_nxt = sha_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_op == sha_pkg::OP_FINISH) begin
            cmd.pad_first = 1'b1;
            cmd.load_work = 1'b1;
          end else begin
            cmd.absorb    = 1'b1;
            cmd.load_work = status.fill_last;
          end
        end
      end
      sha_pkg::ST_ROUND: begin
        cmd.round     = 1'b1;
        cmd.round_idx = rnd_r;
      end
      sha_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        cmd.emit   = final_r;
      end
      sha_pkg::ST_PAD2: begin
        cmd.pad_second = 1'b1;
        cmd.load_work  = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // result valid: set by the final update, cleared by a result transaction
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha_pkg::ST_IDLE;
      rnd_r       <= 6'd0;
      final_r     <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      final_r     <= final_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.absorb, cmd.pad_first, cmd.pad_second, cmd.round, cmd.update}))
    else $error("more than one datapath command at once");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::ST_ROUND) && (rnd_r == 6'd63) |=>
      (state_r == sha_pkg::ST_UPDATE) && (rnd_r == 6'd0))
    else $error("round sequence did not end in the update step");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r)
    else $error("digest written over a pending result");

  a_rose_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sha_pkg::ST_UPDATE)
    else $error("result valid raised outside the final update");

endmodule
`default_nettype wire

### hw/rtl/sha_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_datapath
// Message window, padding, round logic, chaining words, byte and bit counts,
// and the digest result register.
// ----------------------------------------------------------------------------
module sha_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha_pkg::cmd_t     cmd,
  input  wire sha_pkg::in_item_t in_item,
  output sha_pkg::status_t       status,
  output sha_pkg::out_item_t     out_item
);

  logic [31:0]        w_r     [16];
  logic [31:0]        w_nxt   [16];
  logic [31:0]        work_r  [8];
  logic [31:0]        work_nxt[8];
  logic [31:0]        chain_r [8];
  logic [31:0]        chain_sum[8];
  logic [5:0]         fill_r;
  logic [63:0]        bits_r;
  sha_pkg::out_item_t digest_r;
  logic [31:0]        w_new, t1, t2, ch, maj;

  assign status.fill_last = (fill_r == 6'd63);
  assign status.pad_two   = (fill_r >= 6'd56);
  assign out_item         = digest_r;

  // schedule word for the slot sixteen ahead
  assign w_new = sha_pkg::small_sigma1(w_r[14]) + w_r[9] +
                 sha_pkg::small_sigma0(w_r[1]) + w_r[0];

  // compression round terms
  assign ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^
               (work_r[1] & work_r[2]);
  assign t1  = work_r[7] + sha_pkg::big_sigma1(work_r[4]) + ch +
               sha_pkg::ROUND_K[cmd.round_idx] + w_r[0];
  assign t2  = sha_pkg::big_sigma0(work_r[0]) + maj;

  // chaining sum
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_sum[i] = chain_r[i] + work_r[i];
    end
  end

  // message window: byte write, padding, or shift per round
  always_comb begin
    w_nxt = w_r;
    if (cmd.absorb) begin
      for (int j = 0; j < 64; j++) begin
        if (6'(j) == fill_r) begin
          w_nxt[j / 4][8 * (3 - (j % 4)) +: 8] = in_item.data_byte;
        end
      end
    end else if (cmd.pad_first) begin
      for (int j = 0; j < 64; j++) begin
        if (6'(j) == fill_r) begin
          w_nxt[j / 4][8 * (3 - (j % 4)) +: 8] = sha_pkg::PAD_BYTE;
        end else if (6'(j) > fill_r) begin
          w_nxt[j / 4][8 * (3 - (j % 4)) +: 8] = 8'h00;
        end
      end
      if (!status.pad_two) begin
        w_nxt[14] = bits_r[63:32];
        w_nxt[15] = bits_r[31:0];
      end
    end else if (cmd.pad_second) begin
      for (int i = 0; i < 14; i++) begin
        w_nxt[i] = 32'd0;
      end
      w_nxt[14] = bits_r[63:32];
      w_nxt[15] = bits_r[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[15] = w_new;
    end
  end

  // working variables
  always_comb begin
    work_nxt = work_r;
    if (cmd.load_work) begin
      work_nxt = chain_r;
    end else if (cmd.round) begin
      work_nxt[7] = work_r[6];
      work_nxt[6] = work_r[5];
      work_nxt[5] = work_r[4];
      work_nxt[4] = work_r[3] + t1;
      work_nxt[3] = work_r[2];
      work_nxt[2] = work_r[1];
      work_nxt[1] = work_r[0];
      work_nxt[0] = t1 + t2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    work_r <= work_nxt;
    if (cmd.emit) begin
      digest_r.digest_word0 <= {chain_sum[0], chain_sum[1]};
      digest_r.digest_word1 <= {chain_sum[2], chain_sum[3]};
      digest_r.digest_word2 <= {chain_sum[4], chain_sum[5]};
      digest_r.digest_word3 <= {chain_sum[6], chain_sum[7]};
    end
  end

  // hash state and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= sha_pkg::INIT_HASH;
      fill_r  <= 6'd0;
      bits_r  <= 64'd0;
    end else begin
      if (cmd.absorb) begin
        fill_r <= fill_r + 6'd1;
        bits_r <= bits_r + 64'd8;
      end
      if (cmd.update) begin
        if (cmd.emit) begin
          chain_r <= sha_pkg::INIT_HASH;
          fill_r  <= 6'd0;
          bits_r  <= 64'd0;
        end else begin
          chain_r <= chain_sum;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sha256_stream_hasher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream: absorb one byte per transaction, finish to pad
// the message and return the 256-bit digest as four big-endian words.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  in       | in_valid/in_stall  | in_item   (op, data_byte)
//  out      | out_valid/out_stall| out_item  (digest_word0..digest_word3)
//
//  an absorb is accepted only while idle; the byte that fills the block adds 64
//  rounds plus one chaining update, run on the single shared round unit
//  a finish pads one block, or two when fewer than nine block bytes are free
//  reset (rst_n low, synchronous) loads the initial hash and clears the counts
//  the digest waits in an output register; absorbs go on meanwhile, and a
//  finish stalls only until that register is taken
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sha_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sha_pkg::out_item_t      out_item
);

  sha_pkg::cmd_t    cmd;
  sha_pkg::status_t status;

  // controller
  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_item.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  sha_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .status   (status),
    .out_item (out_item)
  );

endmodule
`default_nettype wire
